// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Whenever the antecedent holds, the consequent sequence must follow.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) else $error(msg);

`endif

// ----- rtl/fhtr_pkg.sv -----
// Types, constants and codes shared by the frame hash trace ring modules.
package fhtr_pkg;

   localparam int RING_DEPTH_DEF = 4096;
   localparam int CKPT_DEPTH_DEF = 1024;

   localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

   // Request codes.
   localparam logic [1:0] REQ_RECORD      = 2'd0;
   localparam logic [1:0] REQ_READ_LATEST = 2'd1;
   localparam logic [1:0] REQ_READ_AT     = 2'd2;
   localparam logic [1:0] REQ_CLEAR       = 2'd3;

   // Result kinds.
   localparam logic [1:0] KIND_CAPTURE = 2'd0;
   localparam logic [1:0] KIND_ENTRY   = 2'd1;
   localparam logic [1:0] KIND_EMPTY   = 2'd2;

   // Register file.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] CSR_RING_CAPACITY = 2'd0;
   localparam logic [1:0] CSR_CKPT_INTERVAL = 2'd1;
   localparam logic [1:0] CSR_CKPT_CAPACITY = 2'd2;

   localparam logic [12:0] RING_CAP_RESET     = 13'd4096;
   localparam logic [15:0] CKPT_INTERVAL_RESET = 16'd1;
   localparam logic [10:0] CKPT_CAP_RESET     = 11'd1024;

   // Q16 position constants.
   localparam logic [16:0] POS_ONE  = 17'd65536;
   localparam logic [16:0] POS_HALF = 17'd32768;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  byte_value;
      logic        frame_end;
      logic [31:0] scene_number;
      logic [16:0] normalized_position;
   } fhtr_req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [63:0] frame_number;
      logic [31:0] scene_number_out;
      logic [63:0] frame_digest;
      logic        checkpoint_flag;
      logic [12:0] samples_held;
      logic [10:0] checkpoints_held;
      logic [31:0] frames_evicted;
      logic [31:0] frames_captured;
   } fhtr_rsp_type;

   typedef struct packed {
      logic [63:0] frame_number;
      logic [31:0] scene_number;
      logic [63:0] frame_digest;
      logic        checkpoint_flag;
   } fhtr_sample_type;

   typedef struct packed {
      logic [63:0] frame_number;
      logic [63:0] frame_digest;
   } fhtr_ckpt_type;

   typedef struct packed {
      logic hash_step;
      logic clear_timeline;
      logic load_read;
      logic emit_empty;
      logic capture;
      logic scale;
      logic locate;
      logic fetch;
      logic reply;
   } fhtr_cmd_type;

   typedef struct packed {
      logic ring_empty;
   } fhtr_status_type;

endpackage

// ----- rtl/frame_hash_trace_ring_core.sv -----
// Top level of the frame hash trace ring: sequencer, datapath and checks.
//
// Items enter on req_data when start is high and busy is low. A record byte
// is folded into the running FNV-1a 64 hash and busy stays low,
// so a frame record streams at one byte per cycle. The byte that ends a frame
// holds busy high while the sample is written into the ring in the capture
// state; its capture item then appears on rsp_data from the result register.
// A read of the newest entry or of a position steps through the scale,
// locate, fetch and reply states with busy high: the Q16 scaling multiply,
// rounding and wrapping the index, the registered ring read, and loading
// the result register. A read of an empty ring answers in the cycle after
// acceptance, and a timeline reset keeps busy low and answers nothing.
// Each result is shown for exactly one cycle with rsp_strobe; there is no
// backpressure, and the result register frees the input side at once.
// Registers sit on the APB port at byte addresses 0, 4 and 8; writing any of
// them restarts the timeline and the totals. Reset restores the register
// defaults and empties both rings at once, with no clearing pass.
module frame_hash_trace_ring_core #(
   parameter int RING_DEPTH       = fhtr_pkg::RING_DEPTH_DEF,
   parameter int CHECKPOINT_DEPTH = fhtr_pkg::CKPT_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  fhtr_pkg::fhtr_req_type          req_data,
   output logic                            rsp_strobe,
   output fhtr_pkg::fhtr_rsp_type          rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [fhtr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [fhtr_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [fhtr_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   fhtr_pkg::fhtr_cmd_type    cmd;
   fhtr_pkg::fhtr_status_type status;

   assign pready = 1'b1;

   fhtr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_data.req_type),
      .frame_end (req_data.frame_end),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy)
   );

   fhtr_datapath #(
      .RING_DEPTH       (RING_DEPTH),
      .CHECKPOINT_DEPTH (CHECKPOINT_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_data   (req_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

`include "assert_macros.svh"

   `ASSERT_ALWAYS(a_cmd_exclusive, $onehot0(cmd), "more than one datapath command at once")

   `ASSERT_IMPLIES(a_frame_end_result,
      start && !busy && (req_data.req_type == fhtr_pkg::REQ_RECORD) && req_data.frame_end,
      ##2 rsp_strobe, "frame end item gave no capture result")

   `ASSERT_IMPLIES(a_clear_silent,
      start && !busy && (req_data.req_type == fhtr_pkg::REQ_CLEAR),
      ##1 !rsp_strobe, "timeline reset produced a result")

   `ASSERT_IMPLIES(a_empty_count,
      rsp_strobe && (rsp_data.result_kind == fhtr_pkg::KIND_EMPTY),
      (rsp_data.samples_held == 13'd0), "empty result with entries held")

endmodule

// ----- rtl/fhtr_ctrl.sv -----
// Sequencer that steps the datapath through captures and ring reads.
module fhtr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [1:0]               req_type,
   input  logic                     frame_end,
   input  fhtr_pkg::fhtr_status_type status,
   output fhtr_pkg::fhtr_cmd_type   cmd,
   output logic                     busy
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_CAPTURE = 3'd1;
   localparam logic [2:0] ST_SCALE   = 3'd2;
   localparam logic [2:0] ST_LOCATE  = 3'd3;
   localparam logic [2:0] ST_FETCH   = 3'd4;
   localparam logic [2:0] ST_REPLY   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_type) inside
                  fhtr_pkg::REQ_RECORD: begin
                     cmd.hash_step = 1'b1;
                     if (frame_end) begin
                        state_in = ST_CAPTURE;
                     end
                  end
                  fhtr_pkg::REQ_CLEAR: begin
                     cmd.clear_timeline = 1'b1;
                  end
                  fhtr_pkg::REQ_READ_LATEST, fhtr_pkg::REQ_READ_AT: begin
                     if (status.ring_empty) begin
                        cmd.emit_empty = 1'b1;
                     end else begin
                        cmd.load_read = 1'b1;
                        state_in      = ST_SCALE;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CAPTURE: begin
            cmd.capture = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_LOCATE;
         end
         ST_LOCATE: begin
            cmd.locate = 1'b1;
            state_in   = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_REPLY;
         end
         ST_REPLY: begin
            cmd.reply = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/fhtr_datapath.sv -----
// Hash accumulator, trace rings, read position unit, registers and result register.
module fhtr_datapath #(
   parameter int RING_DEPTH       = fhtr_pkg::RING_DEPTH_DEF,
   parameter int CHECKPOINT_DEPTH = fhtr_pkg::CKPT_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  fhtr_pkg::fhtr_cmd_type             cmd,
   output fhtr_pkg::fhtr_status_type          status,
   input  fhtr_pkg::fhtr_req_type             req_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [fhtr_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [fhtr_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [fhtr_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               rsp_strobe,
   output fhtr_pkg::fhtr_rsp_type             rsp_data
);

   localparam int RW    = $clog2(RING_DEPTH);
   localparam int CW    = $clog2(RING_DEPTH + 1);
   localparam int RCMPW = (CW > 13) ? CW : 13;
   localparam int KW    = $clog2(CHECKPOINT_DEPTH);
   localparam int KCW   = $clog2(CHECKPOINT_DEPTH + 1);
   localparam int KCMPW = (KCW > 11) ? KCW : 11;
   localparam int PW    = RW + 17;

   // Multiply by the FNV prime 2^40 + 0x1b3 as a sum of shifted copies.
   function automatic logic [63:0] fnv_mul(input logic [63:0] x);
      fnv_mul = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

   fhtr_pkg::fhtr_sample_type sample_mem [RING_DEPTH];
   fhtr_pkg::fhtr_ckpt_type   ckpt_mem [CHECKPOINT_DEPTH];

   logic [12:0]   cfg_ring_cap_ff, cfg_ring_cap_in;
   logic [15:0]   cfg_interval_ff, cfg_interval_in;
   logic [10:0]   cfg_ckpt_cap_ff, cfg_ckpt_cap_in;
   logic [63:0]   hash_ff, hash_in;
   logic [RW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [63:0]   next_frame_ff, next_frame_in;
   logic [KW-1:0] ck_head_ff, ck_head_in;
   logic [KCW-1:0] ck_count_ff, ck_count_in;
   logic [15:0]   countdown_ff, countdown_in;
   logic [31:0]   evicted_ff, evicted_in;
   logic [31:0]   captured_ff, captured_in;
   logic [31:0]   scene_ff, scene_in;
   logic [16:0]   pos_ff, pos_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [RW-1:0] idx_ff, idx_in;
   fhtr_pkg::fhtr_sample_type rd_ff;
   fhtr_pkg::fhtr_rsp_type    rsp_ff, rsp_in;
   logic          strobe_ff, strobe_in;

   logic [RCMPW-1:0] rcap_wide;
   logic [CW-1:0]    ring_cap;
   logic [KCMPW-1:0] kcap_wide;
   logic [KCW-1:0]   ckpt_cap;
   logic [RW:0]      wr_sum;
   logic [RW-1:0]    wr_idx;
   logic [KW:0]      ck_sum;
   logic [KW-1:0]    ck_idx;
   logic             is_ckpt;
   logic [RW-1:0]    max_off;
   logic [PW-1:0]    rounded;
   logic [RW:0]      off_wide;
   logic [RW-1:0]    off;
   logic [RW:0]      rd_sum;
   logic             csr_write;
   logic             csr_hit;
   logic [1:0]       csr_index;
   fhtr_pkg::fhtr_sample_type wr_entry;

   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[fhtr_pkg::CSR_ADDR_W-1:2];
   assign csr_hit   = (csr_index == fhtr_pkg::CSR_RING_CAPACITY)
                   || (csr_index == fhtr_pkg::CSR_CKPT_INTERVAL)
                   || (csr_index == fhtr_pkg::CSR_CKPT_CAPACITY);

   // Register values are saturated into the ranges the rings can hold.
   always_comb begin
      rcap_wide = RCMPW'(cfg_ring_cap_ff);
      if (rcap_wide == '0) begin
         ring_cap = CW'(1);
      end else if (rcap_wide > RCMPW'(RING_DEPTH)) begin
         ring_cap = CW'(RING_DEPTH);
      end else begin
         ring_cap = CW'(rcap_wide);
      end
      kcap_wide = KCMPW'(cfg_ckpt_cap_ff);
      if (kcap_wide < KCMPW'(2)) begin
         ckpt_cap = KCW'(2);
      end else if (kcap_wide > KCMPW'(CHECKPOINT_DEPTH)) begin
         ckpt_cap = KCW'(CHECKPOINT_DEPTH);
      end else begin
         ckpt_cap = KCW'(kcap_wide);
      end
   end

   // Slot positions for a capture; head stays below the capacity, so one subtract wraps.
   always_comb begin
      wr_sum = (RW+1)'(head_ff) + (RW+1)'(count_ff);
      if (wr_sum >= (RW+1)'(ring_cap)) begin
         wr_sum = wr_sum - (RW+1)'(ring_cap);
      end
      wr_idx = (count_ff < ring_cap) ? wr_sum[RW-1:0] : head_ff;
      ck_sum = (KW+1)'(ck_head_ff) + (KW+1)'(ck_count_ff);
      if (ck_sum >= (KW+1)'(ckpt_cap)) begin
         ck_sum = ck_sum - (KW+1)'(ckpt_cap);
      end
      ck_idx  = (ck_count_ff < ckpt_cap) ? ck_sum[KW-1:0] : ck_head_ff;
      is_ckpt = (countdown_ff == '0);
      wr_entry.frame_number    = next_frame_ff;
      wr_entry.scene_number    = scene_ff;
      wr_entry.frame_digest    = hash_ff;
      wr_entry.checkpoint_flag = is_ckpt;
   end

   // Read position: offset = ((count - 1) * pos + half) >> 16, then head + offset wrapped.
   always_comb begin
      max_off  = RW'(count_ff - CW'(1));
      rounded  = prod_ff + PW'(fhtr_pkg::POS_HALF);
      off_wide = rounded[PW-1:16];
      off      = (off_wide > (RW+1)'(max_off)) ? max_off : off_wide[RW-1:0];
      rd_sum   = (RW+1)'(head_ff) + (RW+1)'(off);
      if (rd_sum >= (RW+1)'(ring_cap)) begin
         rd_sum = rd_sum - (RW+1)'(ring_cap);
      end
   end

   always_comb begin
      cfg_ring_cap_in = cfg_ring_cap_ff;
      cfg_interval_in = cfg_interval_ff;
      cfg_ckpt_cap_in = cfg_ckpt_cap_ff;
      hash_in         = hash_ff;
      head_in         = head_ff;
      count_in        = count_ff;
      next_frame_in   = next_frame_ff;
      ck_head_in      = ck_head_ff;
      ck_count_in     = ck_count_ff;
      countdown_in    = countdown_ff;
      evicted_in      = evicted_ff;
      captured_in     = captured_ff;
      scene_in        = scene_ff;
      pos_in          = pos_ff;
      prod_in         = prod_ff;
      idx_in          = idx_ff;
      rsp_in          = rsp_ff;
      strobe_in       = 1'b0;

      if (cmd.hash_step) begin
         hash_in  = fnv_mul(hash_ff ^ {56'd0, req_data.byte_value});
         scene_in = req_data.scene_number;
      end

      if (cmd.load_read) begin
         if (req_data.req_type == fhtr_pkg::REQ_READ_LATEST) begin
            // A position of one lands exactly on the newest entry.
            pos_in = fhtr_pkg::POS_ONE;
         end else if (req_data.normalized_position > fhtr_pkg::POS_ONE) begin
            pos_in = fhtr_pkg::POS_ONE;
         end else begin
            pos_in = req_data.normalized_position;
         end
      end

      if (cmd.scale) begin
         prod_in = PW'(max_off) * PW'(pos_ff);
      end

      if (cmd.locate) begin
         idx_in = rd_sum[RW-1:0];
      end

      if (cmd.capture) begin
         if (count_ff < ring_cap) begin
            count_in = count_ff + CW'(1);
         end else begin
            head_in = ((RW+1)'(head_ff) + (RW+1)'(1) == (RW+1)'(ring_cap))
                    ? '0 : head_ff + RW'(1);
            if (evicted_ff != '1) begin
               evicted_in = evicted_ff + 32'd1;
            end
         end
         next_frame_in = next_frame_ff + 64'd1;
         if (is_ckpt) begin
            countdown_in = (cfg_interval_ff == '0) ? '0 : cfg_interval_ff - 16'd1;
            if (ck_count_ff < ckpt_cap) begin
               ck_count_in = ck_count_ff + KCW'(1);
            end else begin
               ck_head_in = ((KW+1)'(ck_head_ff) + (KW+1)'(1) == (KW+1)'(ckpt_cap))
                          ? '0 : ck_head_ff + KW'(1);
            end
         end else begin
            countdown_in = countdown_ff - 16'd1;
         end
         if (captured_ff != '1) begin
            captured_in = captured_ff + 32'd1;
         end
         hash_in = fhtr_pkg::FNV_BASIS;
         rsp_in.result_kind      = fhtr_pkg::KIND_CAPTURE;
         rsp_in.frame_number     = wr_entry.frame_number;
         rsp_in.scene_number_out = wr_entry.scene_number;
         rsp_in.frame_digest     = wr_entry.frame_digest;
         rsp_in.checkpoint_flag  = wr_entry.checkpoint_flag;
         rsp_in.samples_held     = 13'(count_in);
         rsp_in.checkpoints_held = 11'(ck_count_in);
         rsp_in.frames_evicted   = evicted_in;
         rsp_in.frames_captured  = captured_in;
         strobe_in = 1'b1;
      end

      if (cmd.emit_empty) begin
         rsp_in.result_kind      = fhtr_pkg::KIND_EMPTY;
         rsp_in.frame_number     = '0;
         rsp_in.scene_number_out = '0;
         rsp_in.frame_digest     = '0;
         rsp_in.checkpoint_flag  = 1'b0;
         rsp_in.samples_held     = 13'(count_ff);
         rsp_in.checkpoints_held = 11'(ck_count_ff);
         rsp_in.frames_evicted   = evicted_ff;
         rsp_in.frames_captured  = captured_ff;
         strobe_in = 1'b1;
      end

      if (cmd.reply) begin
         rsp_in.result_kind      = fhtr_pkg::KIND_ENTRY;
         rsp_in.frame_number     = rd_ff.frame_number;
         rsp_in.scene_number_out = rd_ff.scene_number;
         rsp_in.frame_digest     = rd_ff.frame_digest;
         rsp_in.checkpoint_flag  = rd_ff.checkpoint_flag;
         rsp_in.samples_held     = 13'(count_ff);
         rsp_in.checkpoints_held = 11'(ck_count_ff);
         rsp_in.frames_evicted   = evicted_ff;
         rsp_in.frames_captured  = captured_ff;
         strobe_in = 1'b1;
      end

      // A register write restarts the timeline and the totals as well.
      if (cmd.clear_timeline || (csr_write && csr_hit)) begin
         hash_in       = fhtr_pkg::FNV_BASIS;
         head_in       = '0;
         count_in      = '0;
         next_frame_in = '0;
         ck_head_in    = '0;
         ck_count_in   = '0;
         countdown_in  = '0;
      end

      if (csr_write && csr_hit) begin
         evicted_in  = '0;
         captured_in = '0;
         unique case (csr_index)
            fhtr_pkg::CSR_RING_CAPACITY: cfg_ring_cap_in = pwdata[12:0];
            fhtr_pkg::CSR_CKPT_INTERVAL: cfg_interval_in = pwdata[15:0];
            fhtr_pkg::CSR_CKPT_CAPACITY: cfg_ckpt_cap_in = pwdata[10:0];
            default: cfg_ring_cap_in = cfg_ring_cap_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         fhtr_pkg::CSR_RING_CAPACITY: prdata = {19'd0, cfg_ring_cap_ff};
         fhtr_pkg::CSR_CKPT_INTERVAL: prdata = {16'd0, cfg_interval_ff};
         fhtr_pkg::CSR_CKPT_CAPACITY: prdata = {21'd0, cfg_ckpt_cap_ff};
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_mem[wr_idx] <= wr_entry;
         if (is_ckpt) begin
            ckpt_mem[ck_idx] <= '{frame_number: next_frame_ff, frame_digest: hash_ff};
         end
      end
      if (cmd.fetch) begin
         rd_ff <= sample_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ring_cap_ff <= fhtr_pkg::RING_CAP_RESET;
         cfg_interval_ff <= fhtr_pkg::CKPT_INTERVAL_RESET;
         cfg_ckpt_cap_ff <= fhtr_pkg::CKPT_CAP_RESET;
         hash_ff         <= fhtr_pkg::FNV_BASIS;
         head_ff         <= '0;
         count_ff        <= '0;
         next_frame_ff   <= '0;
         ck_head_ff      <= '0;
         ck_count_ff     <= '0;
         countdown_ff    <= '0;
         evicted_ff      <= '0;
         captured_ff     <= '0;
         strobe_ff       <= 1'b0;
      end else begin
         cfg_ring_cap_ff <= cfg_ring_cap_in;
         cfg_interval_ff <= cfg_interval_in;
         cfg_ckpt_cap_ff <= cfg_ckpt_cap_in;
         hash_ff         <= hash_in;
         head_ff         <= head_in;
         count_ff        <= count_in;
         next_frame_ff   <= next_frame_in;
         ck_head_ff      <= ck_head_in;
         ck_count_ff     <= ck_count_in;
         countdown_ff    <= countdown_in;
         evicted_ff      <= evicted_in;
         captured_ff     <= captured_in;
         strobe_ff       <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      scene_ff <= scene_in;
      pos_ff   <= pos_in;
      prod_ff  <= prod_in;
      idx_ff   <= idx_in;
      rsp_ff   <= rsp_in;
   end

   assign status.ring_empty = (count_ff == '0);
   assign rsp_strobe        = strobe_ff;
   assign rsp_data          = rsp_ff;

endmodule
